### rtl/dvrs_pkg.sv
// Shared constants, codes and interface types of the distance-vector route solver.
package dvrs_pkg;

    localparam int MAX_NODES   = 8;
    localparam int NODE_BITS   = $clog2(MAX_NODES);
    localparam int SLOTS       = MAX_NODES * MAX_NODES;
    localparam int SLOT_BITS   = 2 * NODE_BITS;
    localparam int ROUND_LIMIT = 100;
    localparam int ROUND_BITS  = $clog2(ROUND_LIMIT + 1);
    localparam int DIST_BITS   = 16;
    localparam int COST_BITS   = 8;
    localparam int COUNT_BITS  = 4;
    localparam int MIN_NODES   = 2;

    localparam logic [DIST_BITS-1:0]  UNREACH = {DIST_BITS{1'b1}};
    localparam logic [DIST_BITS-1:0]  SAT_MAX = {DIST_BITS{1'b1}} - DIST_BITS'(1);
    localparam logic [COUNT_BITS-1:0] NODE_COUNT_RESET = COUNT_BITS'(MAX_NODES);

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_SOLVE = 1'b1
    } cmd_code_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_B,
        ST_ROUND,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_CHECK,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } dvrs_state_t;

    // controller -> datapath
    typedef struct packed {
        logic                 issue;       // relaxation term read (r,k) and (k,c)
        logic                 first;       // first neighbour term of an entry
        logic                 last;        // last neighbour term of an entry
        logic                 emit_rd;     // read (r,c) for output
        logic                 load_a;      // write (src,dst) from the accepted beat
        logic                 load_b;      // write (dst,src) from the latched link
        logic                 swap;        // flip current bank
        logic                 round_start; // clear round change flag
        logic                 clear;       // drop whole table and marks
        logic [NODE_BITS-1:0] r;
        logic [NODE_BITS-1:0] c;
        logic [NODE_BITS-1:0] k;
    } dvrs_cmd_t;

    // datapath -> controller / output
    typedef struct packed {
        logic                 changed;
        logic [DIST_BITS-1:0] distance;
    } dvrs_stat_t;

    // controller -> output packing
    typedef struct packed {
        logic [NODE_BITS-1:0]  row;
        logic [NODE_BITS-1:0]  col;
        logic [ROUND_BITS-1:0] rounds;
        logic                  last;
    } dvrs_emit_t;

endpackage

### rtl/dvrs_datapath.sv
// Datapath: banked distance memory, neighbour marks and the relaxation pipeline.
module dvrs_datapath import dvrs_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dvrs_cmd_t            cmd,
    input  logic [NODE_BITS-1:0] src_node,
    input  logic [NODE_BITS-1:0] dst_node,
    input  logic [COST_BITS-1:0] link_cost,
    output dvrs_stat_t           stat
);

    localparam int ADDR_BITS = SLOT_BITS + 1;

    logic [DIST_BITS-1:0] mem [0:2*SLOTS-1];
    logic [2*SLOTS-1:0]   valid_reg;
    logic [SLOTS-1:0]     mark_reg;
    logic                 cur_reg;
    logic                 changed_reg;

    logic [NODE_BITS-1:0] src_l_reg, dst_l_reg;
    logic [COST_BITS-1:0] cost_l_reg;

    // read side
    logic                 rd_en;
    logic [NODE_BITS-1:0] col_a;
    logic [ADDR_BITS-1:0] addr_a, addr_b;
    logic [DIST_BITS-1:0] rd_a_reg, rd_b_reg;
    logic                 va_reg, vb_reg, da_reg, db_reg;
    logic [DIST_BITS-1:0] a_val, b_val;

    // stage 1 tags
    logic                 s1_valid_reg, s1_first_reg, s1_last_reg, s1_kc_reg;
    logic                 s1_diag_reg, s1_mark_reg;
    logic [SLOT_BITS-1:0] s1_slot_reg;
    logic [DIST_BITS-1:0] best_reg, old_reg;

    // stage 2 write-back
    logic                 s2_valid_reg, s2_diag_reg;
    logic [SLOT_BITS-1:0] s2_slot_reg;
    logic [DIST_BITS-1:0] s2_best_reg, s2_old_reg;

    logic [DIST_BITS:0]   sum;
    logic [DIST_BITS-1:0] sat, best_in, best_next, old_next;
    logic                 cand_ok, upd;

    logic                 wr_en;
    logic [ADDR_BITS-1:0] wr_addr;
    logic [DIST_BITS-1:0] wr_data;

    assign rd_en  = cmd.issue | cmd.emit_rd;
    assign col_a  = cmd.emit_rd ? cmd.c : cmd.k;
    assign addr_a = {cur_reg, cmd.r, col_a};
    assign addr_b = {cur_reg, cmd.k, cmd.c};

    // never-written entries read as the cleared table
    assign a_val = va_reg ? rd_a_reg : (da_reg ? '0 : UNREACH);
    assign b_val = vb_reg ? rd_b_reg : (db_reg ? '0 : UNREACH);

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_a_reg <= mem[addr_a];
            rd_b_reg <= mem[addr_b];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // relaxation term
    always_comb begin
        sum       = {1'b0, a_val} + {1'b0, b_val};
        sat       = (sum > {1'b0, SAT_MAX}) ? SAT_MAX : sum[DIST_BITS-1:0];
        cand_ok   = s1_mark_reg && (b_val != UNREACH);
        best_in   = s1_first_reg ? UNREACH : best_reg;
        best_next = (cand_ok && (sat < best_in)) ? sat : best_in;
        old_next  = s1_kc_reg ? a_val : old_reg;
    end

    assign upd = !s2_diag_reg && (s2_best_reg < s2_old_reg);

    // single write port: round write-back into the other bank, else link loads
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = {cur_reg, src_node, dst_node};
        wr_data = DIST_BITS'(link_cost);
        if (s2_valid_reg) begin
            wr_en   = 1'b1;
            wr_addr = {~cur_reg, s2_slot_reg};
            wr_data = upd ? s2_best_reg : s2_old_reg;
        end else if (cmd.load_a) begin
            wr_en   = 1'b1;
        end else if (cmd.load_b) begin
            wr_en   = 1'b1;
            wr_addr = {cur_reg, dst_l_reg, src_l_reg};
            wr_data = DIST_BITS'(cost_l_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            mark_reg     <= '0;
            cur_reg      <= 1'b0;
            changed_reg  <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= cmd.issue;
            s2_valid_reg <= s1_valid_reg && s1_last_reg;
            if (cmd.clear) begin
                valid_reg   <= '0;
                mark_reg    <= '0;
                cur_reg     <= 1'b0;
                changed_reg <= 1'b0;
            end else begin
                if (wr_en) begin
                    valid_reg[wr_addr] <= 1'b1;
                end
                if (cmd.load_a) begin
                    mark_reg[{src_node, dst_node}] <= 1'b1;
                    mark_reg[{dst_node, src_node}] <= 1'b1;
                end
                if (cmd.swap) begin
                    cur_reg <= ~cur_reg;
                end
                if (cmd.round_start) begin
                    changed_reg <= 1'b0;
                end else if (s2_valid_reg && upd) begin
                    changed_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_a) begin
            src_l_reg  <= src_node;
            dst_l_reg  <= dst_node;
            cost_l_reg <= link_cost;
        end
        if (rd_en) begin
            va_reg <= valid_reg[addr_a];
            vb_reg <= valid_reg[addr_b];
            da_reg <= (cmd.r == col_a);
            db_reg <= (cmd.k == cmd.c);
        end
        if (cmd.issue) begin
            s1_first_reg <= cmd.first;
            s1_last_reg  <= cmd.last;
            s1_kc_reg    <= (cmd.k == cmd.c);
            s1_diag_reg  <= (cmd.r == cmd.c);
            s1_mark_reg  <= mark_reg[{cmd.r, cmd.k}];
            s1_slot_reg  <= {cmd.r, cmd.c};
        end
        if (s1_valid_reg) begin
            best_reg <= best_next;
            old_reg  <= old_next;
            if (s1_last_reg) begin
                s2_best_reg <= best_next;
                s2_old_reg  <= old_next;
                s2_diag_reg <= s1_diag_reg;
                s2_slot_reg <= s1_slot_reg;
            end
        end
    end

    assign stat.changed  = changed_reg;
    assign stat.distance = a_val;

    a_no_wr_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_valid_reg |-> !(cmd.load_a || cmd.load_b))
        else $error("write-back collides with link load");

    a_clear_all: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear |=> (valid_reg == '0 && mark_reg == '0 && !cur_reg && !changed_reg))
        else $error("table not cleared");

    a_s2_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_valid_reg |-> $past(s1_valid_reg && s1_last_reg))
        else $error("write-back without a finished entry");

endmodule

### rtl/dvrs_ctrl.sv
// Controller: node count register, round sequencer and output beat sequencer.
module dvrs_ctrl import dvrs_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic [COUNT_BITS-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  cmd_code_t             s_command,
    input  logic [NODE_BITS-1:0]  s_src,
    input  logic [NODE_BITS-1:0]  s_dst,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  dvrs_stat_t            stat,
    output dvrs_cmd_t             cmd,
    output dvrs_emit_t            emit
);

    dvrs_state_t state_reg, state_next;

    logic [COUNT_BITS-1:0] node_count_reg;
    logic [NODE_BITS-1:0]  r_reg, r_next, c_reg, c_next, k_reg, k_next;
    logic [ROUND_BITS-1:0] round_count_reg, round_count_next;

    logic [COUNT_BITS-1:0] n_live;
    logic [NODE_BITS-1:0]  last_idx;
    logic                  link_ok, k_last, c_last, r_last, entry_last, more_rounds;

    always_comb begin
        if (node_count_reg < COUNT_BITS'(MIN_NODES)) begin
            n_live = COUNT_BITS'(MIN_NODES);
        end else if (node_count_reg > COUNT_BITS'(MAX_NODES)) begin
            n_live = COUNT_BITS'(MAX_NODES);
        end else begin
            n_live = node_count_reg;
        end
    end

    assign last_idx    = NODE_BITS'(n_live - COUNT_BITS'(1));
    assign link_ok     = ({1'b0, s_src} < n_live) && ({1'b0, s_dst} < n_live)
                         && (s_src != s_dst);
    assign k_last      = (k_reg == last_idx);
    assign c_last      = (c_reg == last_idx);
    assign r_last      = (r_reg == last_idx);
    assign entry_last  = r_last && c_last;
    assign more_rounds = stat.changed && (round_count_reg < ROUND_BITS'(ROUND_LIMIT));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_command == CMD_SOLVE) begin
                        state_next = ST_ROUND;
                    end else if (link_ok) begin
                        state_next = ST_LOAD_B;
                    end
                end
            end
            ST_LOAD_B:  state_next = ST_IDLE;
            ST_ROUND: begin
                if (k_last && entry_last) begin
                    state_next = ST_DRAIN1;
                end
            end
            ST_DRAIN1:  state_next = ST_DRAIN2;
            ST_DRAIN2:  state_next = ST_CHECK;
            ST_CHECK:   state_next = more_rounds ? ST_ROUND : ST_EMIT_RD;
            ST_EMIT_RD: state_next = ST_EMIT_OUT;
            ST_EMIT_OUT: begin
                if (m_tready) begin
                    state_next = entry_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd      = '0;
        cmd.r    = r_reg;
        cmd.c    = c_reg;
        cmd.k    = k_reg;
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_command == CMD_SOLVE) begin
                        cmd.round_start = 1'b1;
                    end else if (link_ok) begin
                        cmd.load_a = 1'b1;
                    end
                end
            end
            ST_LOAD_B:  cmd.load_b = 1'b1;
            ST_ROUND: begin
                cmd.issue = 1'b1;
                cmd.first = (k_reg == '0);
                cmd.last  = k_last;
            end
            ST_DRAIN2:  cmd.swap = 1'b1;
            ST_CHECK:   cmd.round_start = more_rounds;
            ST_EMIT_RD: cmd.emit_rd = 1'b1;
            ST_EMIT_OUT: begin
                m_tvalid  = 1'b1;
                cmd.clear = m_tready && entry_last;
            end
            default: ;
        endcase
    end

    // counters
    always_comb begin
        r_next           = r_reg;
        c_next           = c_reg;
        k_next           = k_reg;
        round_count_next = round_count_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_command == CMD_SOLVE) begin
                    r_next = '0;
                    c_next = '0;
                    k_next = '0;
                end
            end
            ST_ROUND: begin
                if (k_last) begin
                    k_next = '0;
                    if (c_last) begin
                        c_next = '0;
                        r_next = r_last ? '0 : r_reg + NODE_BITS'(1);
                    end else begin
                        c_next = c_reg + NODE_BITS'(1);
                    end
                end else begin
                    k_next = k_reg + NODE_BITS'(1);
                end
            end
            ST_DRAIN2:  round_count_next = round_count_reg + ROUND_BITS'(1);
            ST_CHECK: begin
                r_next = '0;
                c_next = '0;
                k_next = '0;
            end
            ST_EMIT_OUT: begin
                if (m_tready) begin
                    if (entry_last) begin
                        r_next           = '0;
                        c_next           = '0;
                        round_count_next = '0;
                    end else if (c_last) begin
                        c_next = '0;
                        r_next = r_reg + NODE_BITS'(1);
                    end else begin
                        c_next = c_reg + NODE_BITS'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            node_count_reg  <= NODE_COUNT_RESET;
            r_reg           <= '0;
            c_reg           <= '0;
            k_reg           <= '0;
            round_count_reg <= '0;
        end else begin
            state_reg       <= state_next;
            r_reg           <= r_next;
            c_reg           <= c_next;
            k_reg           <= k_next;
            round_count_reg <= round_count_next;
            if (cfg_valid) begin
                node_count_reg <= cfg_data;
            end
        end
    end

    assign emit.row    = r_reg;
    assign emit.col    = c_reg;
    assign emit.rounds = round_count_reg;
    assign emit.last   = entry_last;

    a_round_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        round_count_reg <= ROUND_BITS'(ROUND_LIMIT))
        else $error("round count beyond limit");

    a_swap_then_check: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.swap |=> (state_reg == ST_CHECK && round_count_reg != '0))
        else $error("bank swap not followed by round check");

    a_read_then_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_rd |=> m_tvalid)
        else $error("output read not followed by a beat");

endmodule

### rtl/distance_vector_route_solver.sv
// Top level of the distance-vector route solver: ports, packing, controller and datapath.
// Load beat: a link that is ignored is not written; one that is written takes one memory write each way.
// Solve: each round runs n*n*n neighbour terms (one neighbour term per cycle), then drains and checks,
// n = clamped node count; 1 to 100 rounds run, then n*n result beats, each read and then held until taken.
// Input is taken only when the solver is idle; the last result beat clears the table at once.
// aresetn (synchronous, active low) empties the table and marks and sets node_count to 8.
module distance_vector_route_solver import dvrs_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration: node_count
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [COUNT_BITS-1:0] cfg_data,
    // input beats
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,  // [2:0] src_node, [5:3] dst_node, [13:6] link_cost
    input  logic                  s_tuser,  // [0] command: 0 load link, 1 solve
    // result beats
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,  // [2:0] row_node, [5:3] col_node, [21:6] distance,
                                            // [28:22] rounds, [29] converged
    output logic                  m_tlast   // last_entry
);

    dvrs_cmd_t  cmd;
    dvrs_stat_t stat;
    dvrs_emit_t emit;

    logic [NODE_BITS-1:0] src_node, dst_node;
    logic [COST_BITS-1:0] link_cost;
    cmd_code_t            command;

    // unpack the input beat
    assign src_node  = s_tdata[NODE_BITS-1:0];
    assign dst_node  = s_tdata[2*NODE_BITS-1:NODE_BITS];
    assign link_cost = s_tdata[2*NODE_BITS+COST_BITS-1:2*NODE_BITS];
    assign command   = cmd_code_t'(s_tuser);

    // the user must make register writes only while idle; the block does not enforce it, so always take them
    assign cfg_ready = 1'b1;

    dvrs_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_command (command),
        .s_src     (src_node),
        .s_dst     (dst_node),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .stat      (stat),
        .cmd       (cmd),
        .emit      (emit)
    );

    dvrs_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .src_node  (src_node),
        .dst_node  (dst_node),
        .link_cost (link_cost),
        .stat      (stat)
    );

    // result beat: the distance comes straight from the registered memory read,
    // which holds while the beat waits
    assign m_tdata = {2'b00, ~stat.changed, emit.rounds, stat.distance, emit.col, emit.row};
    assign m_tlast = emit.last;

endmodule
